[hw/rtl/rcf_pkg.sv]
`timescale 1ns / 1ps

package rcf_pkg;

	// window geometry
	localparam int KERNEL_SIZE = 5;
	localparam int TAP_COUNT   = KERNEL_SIZE * KERNEL_SIZE;
	localparam int HALF_K      = KERNEL_SIZE / 2;

	// line store layout: one word per column holds four rows
	localparam int PIX_BITS   = 24;
	localparam int STORE_ROWS = 4;
	localparam int SLOT_BITS  = 2;
	localparam int WORD_BITS  = PIX_BITS * STORE_ROWS;

	// configuration register indexes
	localparam logic [2:0] REG_WIDTH     = 3'd0;
	localparam logic [2:0] REG_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_TAPS_LOW  = 3'd2;
	localparam logic [2:0] REG_TAPS_MID  = 3'd3;
	localparam logic [2:0] REG_TAPS_HIGH = 3'd4;
	localparam logic [2:0] REG_TAP_LAST  = 3'd5;
	localparam logic [2:0] REG_SCALE     = 3'd6;
	localparam logic [2:0] REG_OFFSET    = 3'd7;

	// line store access request
	typedef struct packed {
		logic                 rd_en;
		logic                 wr_en;
		logic [SLOT_BITS-1:0] wr_slot;
	} store_req_t;

endpackage

[hw/rtl/rcf_line_store.sv]
`timescale 1ns / 1ps

module rcf_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                          clk,
	input  rcf_pkg::store_req_t           req,
	input  logic [AW-1:0]                 addr,
	input  logic [rcf_pkg::PIX_BITS-1:0]  wr_data,
	output logic [rcf_pkg::WORD_BITS-1:0] rd_data
);

	logic [rcf_pkg::WORD_BITS-1:0] mem [DEPTH];
	logic [rcf_pkg::WORD_BITS-1:0] rd_data_q;

	// one row slot written per beat
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[addr][req.wr_slot*rcf_pkg::PIX_BITS +: rcf_pkg::PIX_BITS] <= wr_data;
		end
	end

	// registered read of all four rows of a column
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/rgb_5x5_convolution_filter_unit.sv]
`timescale 1ns / 1ps

// RGB 5x5 convolution filter on a raster pixel stream.
// Input channel (in_valid/in_ready) carries one pixel per beat, or a drain
// beat that only flushes the frame tail. Output channel (out_valid/out_ready)
// carries one filtered pixel per beat with frame_last on the final pixel.
// Results trail the input by two rows plus two pixels; drain beats after the
// last pixel push out the remaining results.
// One item is processed at a time. A beat passes acceptance, one line store
// read and one window update; a border result (zero) then the tap and final
// steps, and an interior result 25 multiply-accumulate steps over the taps
// (one tap per cycle for all three colours), one scaling multiply and one
// offset and clamp step. The output register lets the next beat be accepted
// while a result waits; a stalled receiver holds the block at its final step
// until it takes that. Reset clears counters, window and registers to their
// defaults; the line store needs no clearing since rows are read only after
// being written. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while idle, as the block does not enforce this.
module rgb_5x5_convolution_filter_unit #(
	parameter int MAX_WIDTH = 1024,
	parameter int TAP_BITS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	input  logic        drain,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        frame_last
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = AW + 1;
	localparam int RW = 13;
	localparam int LW = RW + CW + 1;
	localparam int TB = (TAP_BITS < 8) ? TAP_BITS : 8;
	localparam int SW = TB + 9 + 5;
	localparam int PW = SW + 21;
	localparam int VW = PW - 16 + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_WIN,
		S_MAC,
		S_SCALE,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [10:0]        image_width_q;
	logic [12:0]        image_height_q;
	logic [63:0]        taps_low_q, taps_mid_q, taps_high_q;
	logic [7:0]         tap_last_q;
	logic [19:0]        divide_scale_q;
	logic signed [9:0]  result_offset_q;

	// stream state
	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [rcf_pkg::PIX_BITS-1:0] win_q [rcf_pkg::TAP_COUNT];
	logic [rcf_pkg::PIX_BITS-1:0] pix_q;
	logic                         drain_q;
	logic [LW-1:0]                in_lin_q, out_lin_q;
	logic                         interior_q, last_q;
	logic [4:0]                   mac_cnt_q;
	logic signed [SW-1:0]         sum_q [3];
	logic signed [PW-1:0]         prod_q [3];
	logic                         out_valid_q;
	logic [7:0]                   out_pix_q [3];
	logic                         frame_last_q;

	logic [CW-1:0] eff_w;
	logic [RW-1:0] eff_h;
	logic [LW-1:0] ready_thresh;
	logic [199:0]  taps_flat;
	logic signed [TB-1:0] tap_c;
	logic signed [TB+8:0] mac_prod [3];
	logic [7:0]           clamp_pix [3];
	logic                 out_free;

	rcf_pkg::store_req_t            store_req;
	logic [rcf_pkg::WORD_BITS-1:0]  rd_data;

	// effective frame size
	always_comb begin
		if (image_width_q < 11'd5) begin
			eff_w = CW'(5);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(image_width_q);
		end
		if (image_height_q < 13'd5) begin
			eff_h = RW'(5);
		end else if (image_height_q > 13'd4096) begin
			eff_h = RW'(4096);
		end else begin
			eff_h = image_height_q;
		end
		ready_thresh = LW'({eff_w, 1'b0}) + LW'(2);
	end

	// tap and multiply-accumulate products
	assign taps_flat = {tap_last_q, taps_high_q, taps_mid_q, taps_low_q};
	assign tap_c     = $signed(taps_flat[8*mac_cnt_q +: TB]);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			mac_prod[ch] = tap_c * $signed({1'b0, win_q[mac_cnt_q][8*ch +: 8]});
		end
	end

	// floor scaling, offset and clamp
	always_comb begin
		logic signed [VW-1:0] v;
		v = '0;
		for (int ch = 0; ch < 3; ch++) begin
			v = VW'($signed(prod_q[ch][PW-1:16])) + VW'(result_offset_q);
			if (v < 0) begin
				clamp_pix[ch] = 8'd0;
			end else if (v > VW'(255)) begin
				clamp_pix[ch] = 8'd255;
			end else begin
				clamp_pix[ch] = v[7:0];
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// line store requests
	always_comb begin
		store_req.rd_en   = in_valid && in_ready;
		store_req.wr_en   = (state_q == S_WIN) && !drain_q;
		store_req.wr_slot = in_row_q[1:0];
	end

	rcf_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.req     (store_req),
		.addr    (in_col_q[AW-1:0]),
		.wr_data (pix_q),
		.rd_data (rd_data)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= 11'd1024;
			image_height_q  <= 13'd1024;
			taps_low_q      <= 64'd0;
			taps_mid_q      <= 64'h0000_0001_0000_0000;
			taps_high_q     <= 64'd0;
			tap_last_q      <= 8'd0;
			divide_scale_q  <= 20'd65536;
			result_offset_q <= 10'sd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcf_pkg::REG_WIDTH:     image_width_q   <= cfg_data[10:0];
				rcf_pkg::REG_HEIGHT:    image_height_q  <= cfg_data[12:0];
				rcf_pkg::REG_TAPS_LOW:  taps_low_q      <= cfg_data;
				rcf_pkg::REG_TAPS_MID:  taps_mid_q      <= cfg_data;
				rcf_pkg::REG_TAPS_HIGH: taps_high_q     <= cfg_data;
				rcf_pkg::REG_TAP_LAST:  tap_last_q      <= cfg_data[7:0];
				rcf_pkg::REG_SCALE:     divide_scale_q  <= cfg_data[19:0];
				rcf_pkg::REG_OFFSET:    result_offset_q <= $signed(cfg_data[9:0]);
				default: ;
			endcase
		end
	end

	// item sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			in_col_q     <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			out_valid_q  <= 1'b0;
			frame_last_q <= 1'b0;
			mac_cnt_q    <= '0;
			for (int i = 0; i < rcf_pkg::TAP_COUNT; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pix_q   <= {in_blue, in_green, in_red};
						drain_q <= drain;
						if (!drain && in_col_q == '0 && in_row_q == '0) begin
							out_col_q <= '0;
							out_row_q <= '0;
						end
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					in_lin_q  <= LW'(in_row_q) * LW'(eff_w) + LW'(in_col_q);
					out_lin_q <= LW'(out_row_q) * LW'(eff_w) + LW'(out_col_q);
					state_q   <= S_WIN;
				end
				S_WIN: begin
					logic emit;
					logic [CW-1:0] col_n;
					logic [RW-1:0] row_n;
					if (drain_q) begin
						emit = out_lin_q > in_lin_q;
					end else begin
						emit = in_lin_q >= ready_thresh;
						// shift window and load the new column
						for (int r = 0; r < rcf_pkg::KERNEL_SIZE; r++) begin
							for (int c = 0; c < rcf_pkg::KERNEL_SIZE - 1; c++) begin
								win_q[r*rcf_pkg::KERNEL_SIZE + c] <=
									win_q[r*rcf_pkg::KERNEL_SIZE + c + 1];
							end
						end
						for (int r = 0; r < rcf_pkg::STORE_ROWS; r++) begin
							logic [1:0] slot;
							slot = in_row_q[1:0] + 2'(r);
							if (in_row_q >= RW'(rcf_pkg::STORE_ROWS - r)) begin
								win_q[r*rcf_pkg::KERNEL_SIZE + rcf_pkg::KERNEL_SIZE - 1] <=
									rd_data[slot*rcf_pkg::PIX_BITS +: rcf_pkg::PIX_BITS];
							end else begin
								win_q[r*rcf_pkg::KERNEL_SIZE + rcf_pkg::KERNEL_SIZE - 1] <= '0;
							end
						end
						win_q[rcf_pkg::TAP_COUNT-1] <= pix_q;
						// advance input position
						col_n = in_col_q + CW'(1);
						row_n = in_row_q;
						if (col_n >= eff_w) begin
							col_n = '0;
							row_n = in_row_q + RW'(1);
							if (row_n >= eff_h) begin
								row_n = '0;
							end
						end
						in_col_q <= col_n;
						in_row_q <= row_n;
					end
					if (emit) begin
						interior_q <= (out_col_q >= CW'(rcf_pkg::HALF_K)) &&
							((CW+1)'(out_col_q) + (CW+1)'(rcf_pkg::HALF_K) < (CW+1)'(eff_w)) &&
							(out_row_q >= RW'(rcf_pkg::HALF_K)) &&
							((RW+1)'(out_row_q) + (RW+1)'(rcf_pkg::HALF_K) < (RW+1)'(eff_h));
						last_q <= (out_col_q == eff_w - CW'(1)) && (out_row_q == eff_h - RW'(1));
						// advance output position
						if (out_col_q + CW'(1) >= eff_w) begin
							out_col_q <= '0;
							if (out_row_q + RW'(1) >= eff_h) begin
								out_row_q <= '0;
							end else begin
								out_row_q <= out_row_q + RW'(1);
							end
						end else begin
							out_col_q <= out_col_q + CW'(1);
						end
						for (int ch = 0; ch < 3; ch++) begin
							sum_q[ch] <= '0;
						end
						mac_cnt_q <= '0;
						state_q   <= S_MAC;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MAC: begin
					if (!interior_q) begin
						state_q <= S_DONE;
					end else begin
						for (int ch = 0; ch < 3; ch++) begin
							sum_q[ch] <= sum_q[ch] + SW'(mac_prod[ch]);
						end
						if (mac_cnt_q == 5'(rcf_pkg::TAP_COUNT - 1)) begin
							state_q <= S_SCALE;
						end else begin
							mac_cnt_q <= mac_cnt_q + 5'd1;
						end
					end
				end
				S_SCALE: begin
					for (int ch = 0; ch < 3; ch++) begin
						prod_q[ch] <= PW'(sum_q[ch]) * PW'($signed({1'b0, divide_scale_q}));
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						for (int ch = 0; ch < 3; ch++) begin
							out_pix_q[ch] <= interior_q ? clamp_pix[ch] : 8'd0;
						end
						frame_last_q <= last_q;
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = out_pix_q[0];
	assign out_green  = out_pix_q[1];
	assign out_blue   = out_pix_q[2];
	assign frame_last = frame_last_q;

	// a new result beat only comes from the final step
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result beat raised outside final step");

	// accepted beat always starts a store lookup
	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_LOOK))
		else $error("accepted beat did not start lookup");

	// line store written only for pixel beats at window update
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		store_req.wr_en |-> (state_q == S_WIN && !drain_q))
		else $error("line store written outside window update");

	// tap counter stays inside the kernel
	a_mac_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (mac_cnt_q < 5'(rcf_pkg::TAP_COUNT)))
		else $error("tap counter out of range");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(frame_last_q))
		else $error("pending result lost");

endmodule

[tb/sv/rgb_5x5_convolution_filter_unit_tb.sv]
`timescale 1ns / 1ps

module rgb_5x5_convolution_filter_unit_tb;

	localparam int LINE_MAX   = 1024;
	localparam int CYCLE_CAP  = 6000000;
	localparam int RAND_ITEMS = 1450;

	typedef struct packed {
		logic       drain;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_beat_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} conv_pixel_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_red;
	logic [7:0]  in_green;
	logic [7:0]  in_blue;
	logic        drain;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        frame_last;

	rgb_5x5_convolution_filter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.drain     (drain),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.frame_last(frame_last)
	);

	// shadow of the filter state and registers
	logic [23:0] line_mem [rcf_pkg::STORE_ROWS][LINE_MAX];
	logic [23:0] win [rcf_pkg::TAP_COUNT] = '{default: '0};
	int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
	logic [10:0] cfg_w;
	logic [12:0] cfg_h;
	logic [63:0] taps_lo, taps_mid, taps_hi;
	logic [7:0]  tap_end;
	logic [19:0] scale_q16;
	logic [9:0]  offset_raw;

	pix_beat_t   pix_q [$];
	conv_pixel_t filtered_q [$];
	int          errors = 0;
	int          n_sent = 0;
	int          n_checked = 0;
	int          n_frames = 0;
	longint      cycles = 0;
	bit          quiet;
	int          in_gap;
	int          out_gap;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned line_len();
		if (cfg_w < 5) return 5;
		if (cfg_w > LINE_MAX) return LINE_MAX;
		return 32'(cfg_w);
	endfunction

	function automatic int unsigned frame_rows();
		if (cfg_h < 5) return 5;
		if (cfg_h > 4096) return 4096;
		return 32'(cfg_h);
	endfunction

	function automatic int tap_weight(int t);
		byte b;
		if (t < 8) b = taps_lo[8*t +: 8];
		else if (t < 16) b = taps_mid[8*(t-8) +: 8];
		else if (t < 24) b = taps_hi[8*(t-16) +: 8];
		else b = tap_end;
		return int'(b);
	endfunction

	// weighted sum, q4.16 scale with floor, offset, clamp
	function automatic logic [7:0] filter_chan(int sh);
		int     sum;
		longint prod;
		longint v;
		sum = 0;
		for (int t = 0; t < rcf_pkg::TAP_COUNT; t++)
			sum += tap_weight(t) * int'({24'd0, win[t][sh +: 8]});
		prod = longint'(sum) * longint'({44'd0, scale_q16});
		v = (prod >>> 16) + longint'(signed'(offset_raw));
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	function automatic void push_filtered();
		int unsigned w;
		int unsigned h;
		bit          inner;
		conv_pixel_t p;
		w = line_len();
		h = frame_rows();
		inner = out_col >= rcf_pkg::HALF_K && out_col + rcf_pkg::HALF_K < w &&
			out_row >= rcf_pkg::HALF_K && out_row + rcf_pkg::HALF_K < h;
		p.red   = inner ? filter_chan(0) : 8'd0;
		p.green = inner ? filter_chan(8) : 8'd0;
		p.blue  = inner ? filter_chan(16) : 8'd0;
		p.last  = out_col == w - 1 && out_row == h - 1;
		filtered_q.push_back(p);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) out_row = 0;
		end
	endfunction

	// one accepted beat through the shadow filter
	function automatic void predict_beat(pix_beat_t b);
		int unsigned w;
		int unsigned h;
		int unsigned back;
		bit          fire;
		logic [23:0] pix;
		w = line_len();
		h = frame_rows();
		if (b.drain) begin
			if (out_row * w + out_col > in_row * w + in_col) push_filtered();
			return;
		end
		if (in_col == 0 && in_row == 0) begin
			out_col = 0;
			out_row = 0;
		end
		pix = {b.blue, b.green, b.red};
		for (int r = 0; r < rcf_pkg::KERNEL_SIZE; r++)
			for (int c = 0; c < rcf_pkg::KERNEL_SIZE - 1; c++)
				win[r*rcf_pkg::KERNEL_SIZE + c] = win[r*rcf_pkg::KERNEL_SIZE + c + 1];
		for (int r = 0; r < rcf_pkg::KERNEL_SIZE - 1; r++) begin
			back = rcf_pkg::KERNEL_SIZE - 1 - r;
			win[r*rcf_pkg::KERNEL_SIZE + rcf_pkg::KERNEL_SIZE - 1] = in_row >= back ?
				line_mem[(in_row - back) % rcf_pkg::STORE_ROWS][in_col] : 24'd0;
		end
		win[rcf_pkg::TAP_COUNT - 1] = pix;
		line_mem[in_row % rcf_pkg::STORE_ROWS][in_col] = pix;
		fire = in_row * w + in_col >= rcf_pkg::HALF_K * w + rcf_pkg::HALF_K;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
			if (in_row >= h) in_row = 0;
		end
		if (fire) push_filtered();
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		if (quiet) return 0;
		roll = int'($urandom_range(99));
		if (roll < 65) return 0;
		if (roll < 94) return int'($urandom_range(3, 1));
		return int'($urandom_range(40, 8));
	endfunction

	task automatic report(string what, logic [7:0] got, logic [7:0] want);
		errors++;
		$display("mismatch %0s at result %0d: got %0h want %0h", what, n_checked, got, want);
	endtask

	// pixel driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_red   <= '0;
			in_green <= '0;
			in_blue  <= '0;
			drain    <= 1'b0;
			in_gap   <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_beat({drain, in_red, in_green, in_blue});
				n_sent <= n_sent + 1;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0 || pix_q.size() == 0) begin
					in_valid <= 1'b0;
					if (in_gap > 0) in_gap <= in_gap - 1;
				end else begin
					{drain, in_red, in_green, in_blue} <= pix_q.pop_front();
					in_valid <= 1'b1;
					in_gap   <= pick_gap();
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin
		conv_pixel_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (filtered_q.size() == 0) begin
					errors++;
					$display("unexpected result beat %0d", n_checked);
				end else begin
					want = filtered_q.pop_front();
					if (out_red !== want.red) report("red", out_red, want.red);
					if (out_green !== want.green) report("green", out_green, want.green);
					if (out_blue !== want.blue) report("blue", out_blue, want.blue);
					if (frame_last !== want.last)
						report("frame_last", 8'(frame_last), 8'(want.last));
				end
				n_checked++;
			end
			if (out_gap > 0) begin
				out_ready <= 1'b0;
				out_gap   <= out_gap - 1;
			end else begin
				out_ready <= 1'b1;
				out_gap   <= pick_gap();
			end
		end
	end

	// run watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			rcf_pkg::REG_WIDTH:     cfg_w      = val[10:0];
			rcf_pkg::REG_HEIGHT:    cfg_h      = val[12:0];
			rcf_pkg::REG_TAPS_LOW:  taps_lo    = val;
			rcf_pkg::REG_TAPS_MID:  taps_mid   = val;
			rcf_pkg::REG_TAPS_HIGH: taps_hi    = val;
			rcf_pkg::REG_TAP_LAST:  tap_end    = val[7:0];
			rcf_pkg::REG_SCALE:     scale_q16  = val[19:0];
			rcf_pkg::REG_OFFSET:    offset_raw = val[9:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every beat is in and every result is out
	task automatic settle();
		@(negedge clk);
		while (pix_q.size() != 0 || in_valid || filtered_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// a whole frame of pixels; style 0 random, 1 extremes, 2 flat
	task automatic queue_frame(int style, bit flush);
		int unsigned w;
		int unsigned h;
		int          i;
		pix_beat_t   b;
		logic [7:0]  ext [4];
		ext = '{8'h00, 8'hFF, 8'h55, 8'hAA};
		w = line_len();
		h = frame_rows();
		b = '0;
		b.red = 8'($urandom);
		for (i = 0; i < w * h; i++) begin
			b.drain = 1'b0;
			case (style)
				1: begin
					b.red   = ext[i % 4];
					b.green = ext[(i / 4) % 4];
					b.blue  = ext[(i + 3) % 4];
				end
				2: begin
					b.green = b.red;
					b.blue  = b.red;
				end
				default: {b.red, b.green, b.blue} = 24'($urandom);
			endcase
			pix_q.push_back(b);
			// ignored drain beats inside the frame
			if (style == 0 && $urandom_range(49) == 0) begin
				b.drain = 1'b1;
				pix_q.push_back(b);
			end
		end
		if (flush)
			for (i = 0; i < 2 * w + 2 + $urandom_range(4); i++) begin
				b = 25'($urandom);
				b.drain = 1'b1;
				pix_q.push_back(b);
			end
		n_frames++;
	endtask

	function automatic logic [63:0] rand_taps();
		logic [63:0] v;
		v = {$urandom, $urandom};
		// small weights keep sums in a useful range
		if ($urandom_range(1))
			for (int k = 0; k < 8; k++) v[8*k +: 8] = 8'($urandom_range(6) - 3);
		return v;
	endfunction

	function automatic logic [63:0] rand_scale();
		case ($urandom_range(4))
			0: return 64'd0;
			1: return 64'hFFFFF;
			2: return 64'd65536;
			3: return 64'($urandom_range(8192, 256));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] rand_offset();
		case ($urandom_range(3))
			0: return 64'h200;
			1: return 64'h1FF;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// stimulus and configuration sequence
	initial begin
		int phase;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= rcf_pkg::REG_WIDTH;
		cfg_data  <= '0;
		quiet     = 1'b0;
		cfg_w = 11'd1024; cfg_h = 13'd1024;
		taps_lo = '0; taps_mid = 64'h1_0000_0000; taps_hi = '0; tap_end = '0;
		scale_q16 = 20'd65536; offset_raw = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// identity kernel from reset on a 5x5 frame of extreme values
		write_reg(rcf_pkg::REG_WIDTH, 64'd5);
		write_reg(rcf_pkg::REG_HEIGHT, 64'd5);
		end_writes();
		queue_frame(1, 1'b1);
		settle();

		// all taps at the top and bottom of their range
		write_reg(rcf_pkg::REG_TAPS_LOW, 64'h7F7F_7F7F_7F7F_7F7F);
		write_reg(rcf_pkg::REG_TAPS_MID, 64'h7F7F_7F7F_7F7F_7F7F);
		write_reg(rcf_pkg::REG_TAPS_HIGH, 64'h8080_8080_8080_8080);
		write_reg(rcf_pkg::REG_TAP_LAST, 64'h80);
		write_reg(rcf_pkg::REG_SCALE, 64'hFFFFF);
		write_reg(rcf_pkg::REG_OFFSET, 64'h200);
		end_writes();
		queue_frame(1, 1'b1);
		// next frame starts without a flush, the old tail is dropped
		queue_frame(2, 1'b0);
		queue_frame(2, 1'b1);
		settle();

		// random phases on small frames
		phase = 0;
		while (n_sent < RAND_ITEMS - 100) begin
			write_reg(rcf_pkg::REG_WIDTH, $urandom_range(7) == 0 ?
				64'($urandom_range(4)) : 64'($urandom_range(12, 5)));
			write_reg(rcf_pkg::REG_HEIGHT, $urandom_range(7) == 0 ?
				64'($urandom_range(4)) : 64'($urandom_range(8, 5)));
			write_reg(rcf_pkg::REG_TAPS_LOW, rand_taps());
			write_reg(rcf_pkg::REG_TAPS_MID, rand_taps());
			write_reg(rcf_pkg::REG_TAPS_HIGH, rand_taps());
			write_reg(rcf_pkg::REG_TAP_LAST, {$urandom, $urandom});
			write_reg(rcf_pkg::REG_SCALE, rand_scale());
			write_reg(rcf_pkg::REG_OFFSET, rand_offset());
			end_writes();
			quiet = phase % 5 == 4;
			repeat ($urandom_range(3, 1))
				queue_frame($urandom_range(9) == 0 ? 2 : 0, $urandom_range(7) != 0);
			queue_frame(0, 1'b1);
			settle();
			phase++;
		end

		$display("covered %0d frames in %0d input beats, %0d results checked",
			n_frames, n_sent, n_checked);
		$display("frames from 5x5 to 12x8, undersized sizes clamped, random kernels and scales");
		if (errors == 0 && filtered_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
